// ----- design/hkkm_pkg.sv -----
// ----------------------------------------------------------------------------
// hkkm_pkg
// Shared types and constants for the HID report to key matrix translator.
// ----------------------------------------------------------------------------
package hkkm_pkg;

    localparam int ROW_COUNT  = 8;
    localparam int ROW_WIDTH  = 8;
    localparam int MAP_WIDTH  = ROW_COUNT * ROW_WIDTH;
    localparam int LANE_COUNT = 6;
    localparam int CODE_WIDTH = 8;

    // Modifier byte bit carrying left shift
    localparam int MOD_LSHIFT_BIT = 1;

    // Transaction kinds on the input tuser bit
    localparam logic MODE_REPORT = 1'b0;
    localparam logic MODE_READ   = 1'b1;

    // USB HID usage codes
    localparam logic [7:0] HID_A       = 8'h04;
    localparam logic [7:0] HID_Z       = 8'h1d;
    localparam logic [7:0] HID_1       = 8'h1e;
    localparam logic [7:0] HID_2       = 8'h1f;
    localparam logic [7:0] HID_6       = 8'h23;
    localparam logic [7:0] HID_7       = 8'h24;
    localparam logic [7:0] HID_8       = 8'h25;
    localparam logic [7:0] HID_9       = 8'h26;
    localparam logic [7:0] HID_0       = 8'h27;
    localparam logic [7:0] HID_RETURN  = 8'h28;
    localparam logic [7:0] HID_ESC     = 8'h29;
    localparam logic [7:0] HID_BKSP    = 8'h2a;
    localparam logic [7:0] HID_SPACE   = 8'h2c;
    localparam logic [7:0] HID_DASH    = 8'h2d;
    localparam logic [7:0] HID_EQUALS  = 8'h2e;
    localparam logic [7:0] HID_SEMI    = 8'h33;
    localparam logic [7:0] HID_QUOTE   = 8'h34;
    localparam logic [7:0] HID_CMA     = 8'h36;
    localparam logic [7:0] HID_PERIOD  = 8'h37;
    localparam logic [7:0] HID_FSLASH  = 8'h38;
    localparam logic [7:0] HID_F1      = 8'h3a;
    localparam logic [7:0] HID_ARROW_R = 8'h4f;
    localparam logic [7:0] HID_ARROW_L = 8'h50;
    localparam logic [7:0] HID_ARROW_D = 8'h51;
    localparam logic [7:0] HID_ARROW_U = 8'h52;
    localparam logic [7:0] HID_LCTRL   = 8'he0;
    localparam logic [7:0] HID_LSHIFT  = 8'he1;
    localparam logic [7:0] HID_RCTRL   = 8'he4;
    localparam logic [7:0] HID_RSHIFT  = 8'he5;

    // Bases: code - base is a letter's flat bit, a digit's offset past DIGIT_ROW0
    localparam logic [7:0] LETTER_BASE = 8'h03;
    localparam logic [7:0] DIGIT_BASE  = 8'h1d;
    localparam int         DIGIT_ROW0  = 32;

    // Flat matrix bit positions: row * 8 + bit
    localparam int POS_AT     = 0;
    localparam int POS_0      = 32;
    localparam int POS_QUOTE  = 34;
    localparam int POS_AMP    = 38;
    localparam int POS_8      = 40;
    localparam int POS_9      = 41;
    localparam int POS_COLON  = 42;
    localparam int POS_SEMI   = 43;
    localparam int POS_COMMA  = 44;
    localparam int POS_MINUS  = 45;
    localparam int POS_DOT    = 46;
    localparam int POS_SLASH  = 47;
    localparam int POS_ENTER  = 48;
    localparam int POS_CLEAR  = 49;
    localparam int POS_BREAK  = 50;
    localparam int POS_UP     = 51;
    localparam int POS_DOWN   = 52;
    localparam int POS_LEFT   = 53;
    localparam int POS_RIGHT  = 54;
    localparam int POS_SPACE  = 55;
    localparam int POS_LSHIFT = 56;
    localparam int POS_RSHIFT = 57;
    localparam int POS_CTRL   = 60;

    typedef logic [MAP_WIDTH-1:0] key_map_t;

    // What one decode lane found for its code
    typedef struct packed {
        key_map_t keys;
        logic     kill_shift;
    } lane_out_t;

    // One result transaction
    typedef struct packed {
        logic                 map_changed;
        logic [ROW_WIDTH-1:0] read_data;
    } result_t;

endpackage

// ----- design/hkkm_lane.sv -----
// ----------------------------------------------------------------------------
// hkkm_lane
// Decodes one HID usage code into matrix key bits and a shift kill flag.
// ----------------------------------------------------------------------------
module hkkm_lane
    import hkkm_pkg::*;
(
    input  logic [CODE_WIDTH-1:0] code,
    input  logic                  shift,
    output lane_out_t             result
);

    logic [7:0] letter_pos;
    logic [7:0] digit_pos;
    logic [5:0] digit_idx;

    assign letter_pos = code - LETTER_BASE;
    assign digit_pos  = code - DIGIT_BASE;
    assign digit_idx  = 6'(DIGIT_ROW0) + {2'b00, digit_pos[3:0]};

    // Priority order matters: shifted digits win over the plain digit run
    always_comb
    begin
        result = '0;
        if (code >= HID_A && code <= HID_Z)
        begin
            result.keys[letter_pos[5:0]] = 1'b1;
        end
        else if (code == HID_2 && shift)
        begin
            result.keys[POS_AT] = 1'b1;
            result.kill_shift   = 1'b1;
        end
        else if (code == HID_6 && shift)
        begin
            result.kill_shift = 1'b1;
        end
        else if (code == HID_7 && shift)
        begin
            result.keys[POS_AMP] = 1'b1;
        end
        else if (code == HID_8 && shift)
        begin
            result.keys[POS_COLON] = 1'b1;
        end
        else if (code == HID_9 && shift)
        begin
            result.keys[POS_8]      = 1'b1;
            result.keys[POS_LSHIFT] = 1'b1;
        end
        else if (code == HID_0 && shift)
        begin
            result.keys[POS_9]      = 1'b1;
            result.keys[POS_LSHIFT] = 1'b1;
        end
        else if (code >= HID_1 && code <= HID_9)
        begin
            result.keys[digit_idx] = 1'b1;
        end
        else if (code == HID_0)
        begin
            result.keys[POS_0] = 1'b1;
        end
        else if (code == HID_SEMI)
        begin
            if (shift)
            begin
                result.keys[POS_COLON] = 1'b1;
            end
            else
            begin
                result.keys[POS_SEMI] = 1'b1;
            end
            result.kill_shift = 1'b1;
        end
        else if (code == HID_QUOTE && shift)
        begin
            result.keys[POS_QUOTE]  = 1'b1;
            result.keys[POS_LSHIFT] = 1'b1;
        end
        else if (code == HID_CMA)
        begin
            result.keys[POS_COMMA] = 1'b1;
        end
        else if (code == HID_PERIOD)
        begin
            result.keys[POS_DOT] = 1'b1;
        end
        else if (code == HID_EQUALS)
        begin
            // '=' is shift+minus, '+' is shift+semicolon
            if (shift)
            begin
                result.keys[POS_SEMI] = 1'b1;
            end
            else
            begin
                result.keys[POS_MINUS] = 1'b1;
            end
            result.keys[POS_LSHIFT] = 1'b1;
        end
        else if (code == HID_DASH && !shift)
        begin
            result.keys[POS_MINUS] = 1'b1;
            result.kill_shift      = 1'b1;
        end
        else if (code == HID_FSLASH)
        begin
            result.keys[POS_SLASH] = 1'b1;
        end
        else if (code == HID_RETURN)
        begin
            result.keys[POS_ENTER] = 1'b1;
        end
        else if (code == HID_BKSP || code == HID_ARROW_L)
        begin
            result.keys[POS_LEFT] = 1'b1;
        end
        else if (code == HID_ESC)
        begin
            result.keys[POS_BREAK] = 1'b1;
        end
        else if (code == HID_ARROW_U)
        begin
            result.keys[POS_UP] = 1'b1;
        end
        else if (code == HID_ARROW_D)
        begin
            result.keys[POS_DOWN] = 1'b1;
        end
        else if (code == HID_ARROW_R)
        begin
            result.keys[POS_RIGHT] = 1'b1;
        end
        else if (code == HID_SPACE)
        begin
            result.keys[POS_SPACE] = 1'b1;
        end
        else if (code == HID_F1)
        begin
            result.keys[POS_CLEAR] = 1'b1;
        end
        else if (code == HID_LSHIFT)
        begin
            result.keys[POS_LSHIFT] = 1'b1;
        end
        else if (code == HID_RSHIFT)
        begin
            result.keys[POS_RSHIFT] = 1'b1;
        end
        else if (code == HID_LCTRL || code == HID_RCTRL)
        begin
            result.keys[POS_CTRL] = 1'b1;
        end
    end

endmodule

// ----- design/hkkm_merge.sv -----
// ----------------------------------------------------------------------------
// hkkm_merge
// Merges the lane outputs, holds the key matrix and performs the row read.
// ----------------------------------------------------------------------------
module hkkm_merge
    import hkkm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 mode,
    input  logic [ROW_COUNT-1:0] read_address,
    input  lane_out_t            lanes [LANE_COUNT],
    output result_t              result
);

    key_map_t matrix_rows_reg;
    key_map_t matrix_rows_next;
    key_map_t merged;
    key_map_t read_rows;
    logic     kill;

    always_comb
    begin
        merged = '0;
        kill   = 1'b0;
        for (int i = 0; i < LANE_COUNT; i++)
        begin
            merged = merged | lanes[i].keys;
            kill   = kill | lanes[i].kill_shift;
        end
        // Drop both shift keys when any lane asked for it
        if (kill)
        begin
            merged[POS_LSHIFT] = 1'b0;
            merged[POS_RSHIFT] = 1'b0;
        end
    end

    always_comb
    begin
        matrix_rows_next = matrix_rows_reg;
        if (accept && mode == MODE_REPORT)
        begin
            matrix_rows_next = merged;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_rows_reg <= '0;
        end
        else
        begin
            matrix_rows_reg <= matrix_rows_next;
        end
    end

    // A report reads back the rows it is about to store
    assign read_rows = (mode == MODE_REPORT) ? merged : matrix_rows_reg;

    always_comb
    begin
        result.read_data = '0;
        for (int j = 0; j < ROW_COUNT; j++)
        begin
            if (read_address[j])
            begin
                result.read_data = result.read_data | read_rows[j*ROW_WIDTH +: ROW_WIDTH];
            end
        end
        result.map_changed = (mode == MODE_REPORT) && (merged != matrix_rows_reg);
    end

    a_read_keeps_matrix: assert property (@(posedge clk) disable iff (!rst_n)
        accept && mode == MODE_READ |=> $stable(matrix_rows_reg))
        else $error("matrix changed on a read transaction");

    a_changed_means_update: assert property (@(posedge clk) disable iff (!rst_n)
        accept && result.map_changed |=> matrix_rows_reg != $past(matrix_rows_reg))
        else $error("change flagged but stored rows did not change");

endmodule

// ----- design/hid_keys_to_key_matrix.sv -----
// ----------------------------------------------------------------------------
// hid_keys_to_key_matrix
// USB boot keyboard report to 8 x 8 key matrix translator with row read.
//
//  channel  dir  width  contents
//  s_*      in   64+1   report or read request
//  m_*      out  16     read data and change flag
//
// One transaction per cycle while s_tready is high: six decode lanes and
// the merge/compare are a single combinational stage ahead of the output
// register. Results land in the output register, or in the skid on a stall.
// A two-entry output buffer (register plus skid) keeps s_tready high while one
// result waits; s_tready drops only when both entries are full.
// Reset clears the key matrix to all zero and empties the output buffer.
// ----------------------------------------------------------------------------
module hid_keys_to_key_matrix
    import hkkm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // modifiers, key_code_0 .. key_code_5, read_address
    input  logic [63:0] s_tdata,
    // mode
    input  logic [0:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // read_data, map_changed, zero pad
    output logic [15:0] m_tdata
);

    lane_out_t lanes [LANE_COUNT];
    result_t   result;
    logic      in_fire;
    logic      out_fire;
    logic      shift;

    logic      out_valid_reg;
    logic      out_valid_next;
    result_t   out_data_reg;
    result_t   out_data_next;
    logic      skid_valid_reg;
    logic      skid_valid_next;
    result_t   skid_data_reg;
    result_t   skid_data_next;

    assign shift    = s_tdata[MOD_LSHIFT_BIT];
    assign s_tready = !skid_valid_reg;
    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    for (genvar i = 0; i < LANE_COUNT; i++)
    begin : g_lane
        hkkm_lane u_lane (
            .code   (s_tdata[CODE_WIDTH*(i+1) +: CODE_WIDTH]),
            .shift  (shift),
            .result (lanes[i])
        );
    end

    hkkm_merge u_merge (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (in_fire),
        .mode         (s_tuser[0]),
        .read_address (s_tdata[63:56]),
        .lanes        (lanes),
        .result       (result)
    );

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_fire)
        begin
            // Advance the skid entry first, else load the new result
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = in_fire;
                out_data_next  = result;
            end
        end
        else if (in_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_data_reg.map_changed, out_data_reg.read_data};

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry held while output register empty");

    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && !out_valid_reg |=> out_valid_reg && !skid_valid_reg)
        else $error("accepted transaction not placed in output register");

    a_stall_fills_skid: assert property (@(posedge clk) disable iff (!rst_n)
        in_fire && out_valid_reg && !m_tready |=> skid_valid_reg)
        else $error("transaction accepted under stall was not held in skid");

endmodule
